### sv/mtsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared constants, types and helpers of the markup tag strip filter.
// ----------------------------------------------------------------------------
package mtsf_pkg;

  localparam int TOKEN_MAX   = 32;
  localparam int STORE_DEPTH = TOKEN_MAX;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 6;

  localparam logic [LEN_W-1:0] TOKEN_MAX_L = LEN_W'(TOKEN_MAX);
  localparam logic [LEN_W-1:0] BODY_START  = LEN_W'(2);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SINGLE,
    S_PAIR0,
    S_PAIR1,
    S_BODY_RD,
    S_BODY,
    S_TAIL0,
    S_TAIL1,
    S_CA_RD,
    S_CA
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } store_rd_t;

  function automatic logic [7:0] mul10_add(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] digit;
    digit = {4'b0000, d[3:0]};
    return (acc << 3) + (acc << 1) + digit;
  endfunction

endpackage
`default_nettype wire

### sv/mtsf_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_store
// Tag character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mtsf_store
  import mtsf_pkg::*;
(
  input  wire logic      clk,
  input  wire store_wr_t wr,
  input  wire store_rd_t rd,
  output logic [7:0]     rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

### sv/mtsf_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_seq
// Sequencer: passes plain bytes, collects tag bytes, decodes a closed tag and emits its
// result bytes one at a time; shares one multiply-by-ten accumulator.
// ----------------------------------------------------------------------------
module mtsf_seq
  import mtsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  output logic            emit_valid,
  input  wire logic       emit_ready,
  output logic [7:0]      emit_byte,
  output logic            emit_last,
  output store_wr_t       wr,
  output store_rd_t       rd,
  input  wire logic [7:0] rd_data
);

  state_t           state, state_next;
  logic             tag_open;
  logic [LEN_W-1:0] tag_length;
  logic [7:0]       a, b;
  logic             eot;
  logic [LEN_W-1:0] idx;
  logic [7:0]       ob, p0, p1;
  logic             p1_last, is_w;
  logic             neg, phase_digits;
  logic [7:0]       acc;

  logic       in_fire, emit_fire;
  logic       is_lt, is_gt, room;
  logic       tag_w, tag_rf, tag_rfl, tag_ca, tag_cg, tag_cln, tag_cm, long_enough;
  logic       d_blank, d_sign, d_digit, idx_end;
  logic [7:0] ca_value;

  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = emit_valid && emit_ready;
  assign is_lt     = in_byte == CH_LT;
  assign is_gt     = in_byte == CH_GT;
  assign room      = tag_length < TOKEN_MAX_L;

  assign long_enough = tag_length >= BODY_START;
  assign tag_w   = (a == CH_W) && (b == CH_G || b == CH_H || b == CH_T);
  assign tag_rf  = (a == CH_R) && (b == CH_F);
  assign tag_rfl = (a == CH_R) && (b == CH_F_LO);
  assign tag_ca  = (a == CH_C) && (b == CH_A);
  assign tag_cg  = (a == CH_C) && (b == CH_G);
  assign tag_cln = (a == CH_C) && (b == CH_L || b == CH_N);
  assign tag_cm  = (a == CH_C) && (b == CH_M);

  assign d_blank  = (rd_data == CH_SP) || (rd_data inside {[CH_TAB:CH_CR]});
  assign d_sign   = (rd_data == CH_PLUS) || (rd_data == CH_MINUS);
  assign d_digit  = rd_data inside {[CH_0:CH_9]};
  assign idx_end  = idx >= tag_length;
  assign ca_value = neg ? 8'(8'd0 - acc) : acc;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (is_gt) begin
            state_next = S_DECODE;
          end else if (!is_lt && !tag_open) begin
            state_next = S_SINGLE;
          end
        end
      end
      S_DECODE: begin
        if (!long_enough) begin
          state_next = S_IDLE;
        end else if (tag_w || tag_rf || tag_rfl || tag_cm) begin
          state_next = S_PAIR0;
        end else if (tag_ca) begin
          state_next = S_CA_RD;
        end else if (tag_cg || tag_cln) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SINGLE: if (emit_fire) state_next = S_IDLE;
      S_PAIR0:  if (emit_fire) state_next = S_PAIR1;
      S_PAIR1:  if (emit_fire) state_next = is_w ? S_BODY_RD : S_IDLE;
      S_BODY_RD: state_next = idx_end ? S_TAIL0 : S_BODY;
      S_BODY:   if (emit_fire) state_next = S_BODY_RD;
      S_TAIL0:  if (emit_fire) state_next = S_TAIL1;
      S_TAIL1:  if (emit_fire) state_next = S_IDLE;
      S_CA_RD:  state_next = idx_end ? S_SINGLE : S_CA;
      S_CA: begin
        if ((!phase_digits && (d_blank || d_sign)) || d_digit) begin
          state_next = S_CA_RD;
        end else begin
          state_next = S_SINGLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = state != S_IDLE;
    emit_valid = 1'b0;
    emit_byte  = ob;
    emit_last  = 1'b0;
    rd.en      = 1'b0;
    rd.addr    = idx[IDX_W-1:0];
    wr.en      = in_fire && !is_lt && !is_gt && tag_open && room;
    wr.addr    = tag_length[IDX_W-1:0];
    wr.data    = in_byte;
    case (state)
      S_SINGLE: begin
        emit_valid = 1'b1;
        emit_byte  = ob;
        emit_last  = 1'b1;
      end
      S_PAIR0: begin
        emit_valid = 1'b1;
        emit_byte  = p0;
      end
      S_PAIR1: begin
        emit_valid = 1'b1;
        emit_byte  = p1;
        emit_last  = p1_last;
      end
      S_BODY_RD: rd.en = !idx_end;
      S_BODY: begin
        emit_valid = 1'b1;
        emit_byte  = rd_data;
      end
      S_TAIL0: begin
        emit_valid = 1'b1;
        emit_byte  = CH_GT;
      end
      S_TAIL1: begin
        emit_valid = 1'b1;
        emit_byte  = CH_SP;
        emit_last  = 1'b1;
      end
      S_CA_RD: rd.en = !idx_end;
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tag_open   <= 1'b0;
      tag_length <= '0;
      eot        <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            eot <= end_of_text;
            if (is_gt) begin
              tag_open <= 1'b0;
            end else if (end_of_text) begin
              tag_open   <= 1'b0;
              tag_length <= '0;
              ob         <= in_byte;
            end else if (is_lt) begin
              tag_open   <= 1'b1;
              tag_length <= '0;
            end else if (tag_open) begin
              if (room) begin
                tag_length <= tag_length + 1'b1;
                if (tag_length == '0) a <= in_byte;
                if (tag_length == LEN_W'(1)) b <= in_byte;
              end
            end else begin
              ob <= in_byte;
            end
          end
        end
        S_DECODE: begin
          idx          <= BODY_START;
          acc          <= '0;
          neg          <= 1'b0;
          phase_digits <= 1'b0;
          is_w         <= tag_w;
          p1_last      <= !tag_w;
          if (tag_w) begin
            p0 <= CH_SP;
            p1 <= CH_LT;
          end else if (tag_rf) begin
            p0 <= CH_SP;
            p1 <= CH_LBR;
          end else if (tag_rfl) begin
            p0 <= CH_RBR;
            p1 <= CH_SP;
          end else begin
            p0 <= CH_NL;
            p1 <= CH_NL;
          end
          ob <= tag_cg ? CH_GT : CH_NL;
        end
        S_BODY: if (emit_fire) idx <= idx + 1'b1;
        S_CA_RD: if (idx_end) ob <= ca_value;
        S_CA: begin
          if (!phase_digits && d_blank) begin
            idx <= idx + 1'b1;
          end else if (!phase_digits && d_sign) begin
            neg          <= rd_data == CH_MINUS;
            phase_digits <= 1'b1;
            idx          <= idx + 1'b1;
          end else if (d_digit) begin
            acc          <= mul10_add(acc, rd_data);
            phase_digits <= 1'b1;
            idx          <= idx + 1'b1;
          end else begin
            ob <= ca_value;
          end
        end
        default: begin
        end
      endcase
      if (state != S_IDLE && state_next == S_IDLE && eot) begin
        tag_open   <= 1'b0;
        tag_length <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/markup_tag_strip_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a plain byte passes the sequencer byte register and then the output register.
// Flow: the input stalls whenever the sequencer leaves idle, so tag bytes flow on, but
//   after a plain byte the input waits until it is emitted and after a '>' until its
//   result bytes are done: fixed bytes, tag body bytes each read from the single store
//   read port, and a CA value scanned from the tag bytes through that port; output stalls hold the sequencer longer.
// Reset: rst clears the sequencer, tag flag, tag length and output valid;
//   the tag store needs no clearing pass.
// ----------------------------------------------------------------------------
// markup_tag_strip_filter_core
// Top level: tag sequencer, tag store and output register.
// ----------------------------------------------------------------------------
module markup_tag_strip_filter_core
  import mtsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  logic       emit_valid, emit_ready, emit_last;
  logic [7:0] emit_byte, rd_data;
  store_wr_t  wr;
  store_rd_t  rd;

  assign emit_ready = !out_valid || !out_stall;

  mtsf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .emit_valid  (emit_valid),
    .emit_ready  (emit_ready),
    .emit_byte   (emit_byte),
    .emit_last   (emit_last),
    .wr          (wr),
    .rd          (rd),
    .rd_data     (rd_data)
  );

  mtsf_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

endmodule
`default_nettype wire
